// ----- rtl/core/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Holds the command and result word layouts and the operation codes.
// Depends on nothing.
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE        = 8'd10;
    localparam logic [7:0] CHAR_BLANK          = 8'd32;
    localparam logic [7:0] CHAR_CLEAR          = 8'h00;
    localparam logic [7:0] DEFAULT_COLOR_RESET = 8'd15;

    typedef struct packed {
        logic [1:0] op;
        logic       is_newline;
        logic       bad_pos;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [4:0] row;
        logic [6:0] col;
    } cmd_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic       scrolled;
        logic       status;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcw_fifo.sv -----
// Small synchronous queue of words used between the console stages.
// Depends on nothing.
`default_nettype none

module tcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PW + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tcw_front.sv -----
// Front end of the text console writer: accepts words, holds the color register
// and classifies each word into a command for the execution engine.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  character,
    input  wire logic [7:0]  color,
    input  wire logic [4:0]  row,
    input  wire logic [6:0]  col,
    input  wire logic        cmd_full,
    input  wire logic        init_busy,
    output logic             cmd_push,
    output tcw_pkg::cmd_t    cmd,
    output logic [7:0]       dflt_color
);
    import tcw_pkg::*;

    logic [7:0] default_color_reg;

    assign cfg_ready  = 1'b1;
    assign dflt_color = default_color_reg;
    assign full       = cmd_full || init_busy;
    assign cmd_push   = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= DEFAULT_COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            default_color_reg <= cfg_data;
        end
    end

    always_comb
    begin
        cmd.op         = operation;
        cmd.is_newline = (character == CHAR_NEWLINE);
        cmd.bad_pos    = (32'(row) >= 32'(ROWS)) || (32'(col) >= 32'(COLS));
        cmd.ch         = character;
        cmd.attr       = (color == 8'd0) ? default_color_reg : color;
        cmd.row        = row;
        cmd.col        = col;
    end

endmodule

`default_nettype wire

// ----- rtl/core/tcw_back.sv -----
// Execution engine of the text console writer: owns the cell memory and the
// cursor, and carries out puts, cursor moves, clears, scrolls and reads.
// Depends on tcw_pkg.
`default_nettype none

module tcw_back #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tcw_pkg::cmd_t  cmd,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    input  wire logic [7:0]     dflt_color,
    input  wire logic           res_full,
    output logic                res_push,
    output tcw_pkg::res_t       res,
    output logic                init_busy
);
    import tcw_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int CELLS = ROWS * COLS;
    localparam int COPY  = (ROWS - 1) * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);

    localparam logic [1:0] S_FILL   = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_SCROLL = 2'd3;

    logic [15:0]   mem [CELLS];
    logic [15:0]   rd_data_reg;

    logic [1:0]    state_reg,      state_next;
    logic [NW-1:0] cnt_reg,        cnt_next;
    logic [RW-1:0] cur_row_reg,    cur_row_next;
    logic [CW-1:0] cur_col_reg,    cur_col_next;
    logic [7:0]    fill_color_reg, fill_color_next;
    logic          fill_reply_reg, fill_reply_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    logic [CW:0]   adv_col;
    logic [RW:0]   adv_row;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] pos_addr;
    logic [NW-1:0] cnt_prev;

    assign init_busy = (state_reg == S_FILL) && !fill_reply_reg;
    assign cur_addr  = AW'(cur_row_reg * COLS) + AW'(cur_col_reg);
    assign pos_addr  = AW'(cmd.row * COLS) + AW'(cmd.col);
    assign cnt_prev  = cnt_reg - 1'b1;

    always_comb
    begin
        if (cmd.is_newline || ({1'b0, cur_col_reg} + 1'b1) == (CW + 1)'(COLS))
        begin
            adv_col = '0;
            adv_row = {1'b0, cur_row_reg} + 1'b1;
        end
        else
        begin
            adv_col = {1'b0, cur_col_reg} + 1'b1;
            adv_row = {1'b0, cur_row_reg};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        fill_color_next = fill_color_reg;
        fill_reply_next = fill_reply_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        mem_re          = 1'b0;
        mem_ra          = '0;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res.cell_char   = 8'd0;
        res.cell_color  = 8'd0;
        res.scrolled    = 1'b0;
        res.status      = 1'b0;

        case (state_reg)
            S_FILL:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg[AW-1:0];
                mem_wd = {fill_color_reg, CHAR_CLEAR};
                if (cnt_reg == NW'(CELLS - 1))
                begin
                    res_push   = fill_reply_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUT:
                        begin
                            if (!cmd.is_newline)
                            begin
                                mem_we = 1'b1;
                                mem_wa = cur_addr;
                                mem_wd = {cmd.attr, cmd.ch};
                            end
                            cur_col_next = adv_col[CW-1:0];
                            if (adv_row == (RW + 1)'(ROWS))
                            begin
                                cur_row_next = RW'(ROWS - 1);
                                cnt_next     = '0;
                                state_next   = S_SCROLL;
                            end
                            else
                            begin
                                cur_row_next = adv_row[RW-1:0];
                                res_push     = 1'b1;
                            end
                        end
                        OP_SET:
                        begin
                            if (!cmd.bad_pos)
                            begin
                                cur_row_next = RW'(cmd.row);
                                cur_col_next = CW'(cmd.col);
                            end
                            res.status = cmd.bad_pos;
                            res_push   = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            fill_color_next = dflt_color;
                            fill_reply_next = 1'b1;
                            cnt_next        = '0;
                            state_next      = S_FILL;
                        end
                        OP_READ:
                        begin
                            if (cmd.bad_pos)
                            begin
                                res.status = 1'b1;
                                res_push   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = pos_addr;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res.cell_char  = rd_data_reg[7:0];
                res.cell_color = rd_data_reg[15:8];
                res_push       = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCROLL:
            begin
                if (cnt_reg < NW'(COPY))
                begin
                    mem_re = 1'b1;
                    mem_ra = AW'(cnt_reg + NW'(COLS));
                end
                if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = cnt_prev[AW-1:0];
                    mem_wd = (cnt_reg <= NW'(COPY)) ? rd_data_reg : {dflt_color, CHAR_BLANK};
                end
                if (cnt_reg == NW'(CELLS))
                begin
                    res.scrolled = 1'b1;
                    res_push     = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.cursor_row = 5'(cur_row_next);
        res.cursor_col = 7'(cur_col_next);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            cnt_reg        <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            fill_color_reg <= DEFAULT_COLOR_RESET;
            fill_reply_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            fill_color_reg <= fill_color_next;
            fill_reply_reg <= fill_reply_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer_core.sv -----
// Top level of the text console writer: front end, command queue, execution
// engine and result queue. Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back.
`default_nettype none

// The console keeps a ROWS x COLS grid of 16-bit cells in a single-port-write
// memory and executes one word at a time. A read goes through a registered
// memory read. A clear and a put that scrolls both sweep the grid through the
// one write port of the cell memory. Each word reaches the engine through the
// registered command queue, and each result reaches the result ports through
// the registered result queue.
// After reset a clearing pass over all ROWS*COLS cells (2000 by default) fills
// the memory while full stays high; configuration writes are still taken.

module text_console_writer_core #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] character,
    input  wire logic [7:0] color,
    input  wire logic [4:0] row,
    input  wire logic [6:0] col,
    output logic            empty,
    input  wire logic       pop,
    output logic [4:0]      cursor_row,
    output logic [6:0]      cursor_col,
    output logic [7:0]      cell_char,
    output logic [7:0]      cell_color,
    output logic            scrolled,
    output logic            status
);
    import tcw_pkg::*;

    cmd_t       front_cmd;
    cmd_t       back_cmd;
    res_t       back_res;
    res_t       out_res;
    logic       cmd_push;
    logic       cmd_full;
    logic       cmd_empty;
    logic       cmd_pop;
    logic       res_push;
    logic       res_full;
    logic       init_busy;
    logic [7:0] dflt_color;

    tcw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .character  (character),
        .color      (color),
        .row        (row),
        .col        (col),
        .cmd_full   (cmd_full),
        .init_busy  (init_busy),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd),
        .dflt_color (dflt_color)
    );

    tcw_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    tcw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (back_cmd),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .dflt_color (dflt_color),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res),
        .init_busy  (init_busy)
    );

    tcw_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign cursor_row = out_res.cursor_row;
    assign cursor_col = out_res.cursor_col;
    assign cell_char  = out_res.cell_char;
    assign cell_color = out_res.cell_color;
    assign scrolled   = out_res.scrolled;
    assign status     = out_res.status;

endmodule

`default_nettype wire

// ----- tb/text_console_writer_core_tb.sv -----
// Self-checking testbench for text_console_writer_core: a directed table, then random
// phases at several default colors; results match given words or a cell-level predictor.
// Depends on tcw_pkg and text_console_writer_core.
`timescale 1ns / 100ps

module text_console_writer_core_tb;

    import tcw_pkg::*;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int CELLS = ROWS * COLS;
    localparam int PHASE_WORDS = 110;
    localparam int SINK_HOLD = 400;

    typedef struct {
        logic [1:0] op;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [4:0] r;
        logic [6:0] c;
    } console_cmd_t;

    typedef struct {
        console_cmd_t cmd;
        bit           typed;
        res_t         want;
    } table_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       push;
    logic       full;
    logic [1:0] operation;
    logic [7:0] character;
    logic [7:0] color;
    logic [4:0] row;
    logic [6:0] col;
    logic       empty;
    logic       pop;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic       scrolled;
    logic       status;

    logic [15:0] screen_model [0:CELLS-1];
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;
    logic [7:0]  dflt_color;

    res_t        pending_results [$];
    table_row_t  directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned clears_left = 6;
    int unsigned hold_cycles = 0;
    int unsigned pop_wait = 0;
    bit          stall_sink = 0;
    bit          no_idle = 0;

    text_console_writer_core #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .operation(operation),
        .character(character),
        .color(color),
        .row(row),
        .col(col),
        .empty(empty),
        .pop(pop),
        .cursor_row(cursor_row),
        .cursor_col(cursor_col),
        .cell_char(cell_char),
        .cell_color(cell_color),
        .scrolled(scrolled),
        .status(status)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void fill_screen(input logic [15:0] fill_value);
        int i;
        for (i = 0; i < CELLS; i++)
            screen_model[i] = fill_value;
    endfunction

    function automatic res_t console_apply(input console_cmd_t cmd);
        res_t res;
        int   nr;
        int   nc;
        int   i;
        res = '0;
        case (cmd.op)
            OP_PUT:
            begin
                nr = cur_row;
                nc = cur_col;
                if (cmd.ch != CHAR_NEWLINE)
                begin
                    screen_model[nr * COLS + nc] =
                        {((cmd.attr != 8'd0) ? cmd.attr : dflt_color), cmd.ch};
                    nc++;
                    if (nc >= COLS)
                    begin
                        nc = 0;
                        nr++;
                    end
                end
                else
                begin
                    nc = 0;
                    nr++;
                end
                if (nr >= ROWS)
                begin
                    for (i = 0; i < (ROWS - 1) * COLS; i++)
                        screen_model[i] = screen_model[i + COLS];
                    for (i = (ROWS - 1) * COLS; i < CELLS; i++)
                        screen_model[i] = {dflt_color, CHAR_BLANK};
                    nr = ROWS - 1;
                    res.scrolled = 1'b1;
                end
                cur_row = nr[4:0];
                cur_col = nc[6:0];
            end
            OP_SET:
            begin
                if (cmd.r >= ROWS || cmd.c >= COLS)
                    res.status = 1'b1;
                else
                begin
                    cur_row = cmd.r;
                    cur_col = cmd.c;
                end
            end
            OP_CLEAR:
            begin
                fill_screen({dflt_color, CHAR_CLEAR});
                cur_row = '0;
                cur_col = '0;
            end
            default:
            begin
                if (cmd.r >= ROWS || cmd.c >= COLS)
                    res.status = 1'b1;
                else
                begin
                    res.cell_char = screen_model[cmd.r * COLS + cmd.c][7:0];
                    res.cell_color = screen_model[cmd.r * COLS + cmd.c][15:8];
                end
            end
        endcase
        res.cursor_row = cur_row;
        res.cursor_col = cur_col;
        return res;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned pick;
        if (no_idle || hold_cycles > 0)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // Most set and read words land in range; some aim at the bottom right corner so
    // that puts wrap and scroll, and some reads look at the cell just written.
    function automatic console_cmd_t random_cmd();
        console_cmd_t cmd;
        int unsigned  pick;
        int unsigned  sel;
        cmd.op = OP_PUT;
        cmd.ch = 8'($urandom_range(0, 255));
        cmd.attr = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        cmd.r = 5'($urandom_range(0, 31));
        cmd.c = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        if (pick < 2 && clears_left > 0)
        begin
            cmd.op = OP_CLEAR;
            clears_left--;
        end
        else if (pick < 62)
        begin
            if ($urandom_range(0, 11) == 0)
                cmd.ch = CHAR_NEWLINE;
        end
        else if (pick < 85)
        begin
            cmd.op = OP_SET;
            if (sel < 3)
            begin
                cmd.r = 5'(ROWS - 1);
                cmd.c = 7'($urandom_range(COLS - 10, COLS - 1));
            end
            else if (sel < 8)
            begin
                cmd.r = 5'($urandom_range(0, ROWS - 1));
                cmd.c = 7'($urandom_range(0, COLS - 1));
            end
        end
        else
        begin
            cmd.op = OP_READ;
            if (sel < 4)
            begin
                cmd.r = cur_row;
                cmd.c = (cur_col > 0) ? cur_col - 7'd1 : 7'd0;
            end
            else if (sel < 8)
            begin
                cmd.r = 5'($urandom_range(0, ROWS - 1));
                cmd.c = 7'($urandom_range(0, COLS - 1));
            end
        end
        return cmd;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] attr,
                           input logic [4:0] r, input logic [6:0] c, input bit typed,
                           input res_t want);
        table_row_t entry;
        entry.cmd.op = op;
        entry.cmd.ch = ch;
        entry.cmd.attr = attr;
        entry.cmd.r = r;
        entry.cmd.c = c;
        entry.typed = typed;
        entry.want = want;
        directed_rows.push_back(entry);
    endtask

    task automatic send_cmd(input console_cmd_t cmd, input bit typed, input res_t typed_res);
        res_t predicted;
        operation = cmd.op;
        character = cmd.ch;
        color = cmd.attr;
        row = cmd.r;
        col = cmd.c;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        predicted = console_apply(cmd);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        int unsigned gap;
        gap = idle_len();
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic finish_phase();
        push = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_default_color(input logic [7:0] value);
        cfg_data = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        dflt_color = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_sink)
            begin
                stall_sink = 0;
                hold_cycles = SINK_HOLD;
            end
            if (hold_cycles > 0)
            begin
                pop = 1'b0;
                hold_cycles--;
            end
            else if (pop_wait > 0)
            begin
                pop = 1'b0;
                pop_wait--;
            end
            else
                pop = 1'b1;
        end
    end

    initial
    begin
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("cursor_row", want.cursor_row, cursor_row);
                    check_field("cursor_col", want.cursor_col, cursor_col);
                    check_field("cell_char", want.cell_char, cell_char);
                    check_field("cell_color", want.cell_color, cell_color);
                    check_field("scrolled", want.scrolled, scrolled);
                    check_field("status", want.status, status);
                end
                pop_wait = idle_len();
            end
        end
    end

    initial
    begin
        logic [7:0] phase_color [0:4];
        int         p;
        int         n;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        operation = OP_PUT;
        character = '0;
        color = '0;
        row = '0;
        col = '0;
        dflt_color = DEFAULT_COLOR_RESET;
        cur_row = '0;
        cur_col = '0;
        fill_screen({DEFAULT_COLOR_RESET, CHAR_CLEAR});

        add_row(OP_READ, 8'd0, 8'd0, 5'd0, 7'd0, 1, {5'd0, 7'd0, 8'd0, 8'd15, 2'b00});
        add_row(OP_READ, 8'd0, 8'd0, 5'd24, 7'd79, 1, {5'd0, 7'd0, 8'd0, 8'd15, 2'b00});
        add_row(OP_READ, 8'd0, 8'd0, 5'd25, 7'd0, 1, {5'd0, 7'd0, 8'd0, 8'd0, 2'b01});
        add_row(OP_READ, 8'd0, 8'd0, 5'd0, 7'd80, 1, {5'd0, 7'd0, 8'd0, 8'd0, 2'b01});
        add_row(OP_READ, 8'hFF, 8'hFF, 5'd31, 7'd127, 1, {5'd0, 7'd0, 8'd0, 8'd0, 2'b01});
        add_row(OP_SET, 8'd0, 8'd0, 5'd31, 7'd127, 1, {5'd0, 7'd0, 8'd0, 8'd0, 2'b01});
        add_row(OP_SET, 8'd0, 8'd0, 5'd24, 7'd80, 1, {5'd0, 7'd0, 8'd0, 8'd0, 2'b01});
        add_row(OP_PUT, 8'h41, 8'd0, 5'd0, 7'd0, 1, {5'd0, 7'd1, 8'd0, 8'd0, 2'b00});
        add_row(OP_READ, 8'd0, 8'd0, 5'd0, 7'd0, 1, {5'd0, 7'd1, 8'h41, 8'd15, 2'b00});
        add_row(OP_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127, 0, '0);
        add_row(OP_SET, 8'd0, 8'd0, 5'd0, 7'd79, 1, {5'd0, 7'd79, 8'd0, 8'd0, 2'b00});
        add_row(OP_PUT, 8'h00, 8'h80, 5'd0, 7'd0, 0, '0);
        add_row(OP_SET, 8'd0, 8'd0, 5'd3, 7'd79, 0, '0);
        add_row(OP_PUT, CHAR_NEWLINE, 8'h33, 5'd0, 7'd0, 0, '0);
        add_row(OP_SET, 8'd0, 8'd0, 5'd24, 7'd79, 0, '0);
        add_row(OP_PUT, 8'h5A, 8'h01, 5'd0, 7'd0, 0, '0);
        add_row(OP_READ, 8'd0, 8'd0, 5'd23, 7'd79, 0, '0);
        add_row(OP_READ, 8'd0, 8'd0, 5'd24, 7'd5, 0, '0);
        add_row(OP_PUT, CHAR_NEWLINE, 8'd0, 5'd0, 7'd0, 0, '0);
        add_row(OP_READ, 8'd0, 8'd0, 5'd0, 7'd0, 0, '0);
        add_row(OP_CLEAR, 8'd0, 8'd0, 5'd0, 7'd0, 1, {5'd0, 7'd0, 8'd0, 8'd0, 2'b00});
        add_row(OP_READ, 8'd0, 8'd0, 5'd12, 7'd40, 1, {5'd0, 7'd0, 8'd0, 8'd15, 2'b00});
        add_row(OP_SET, 8'd0, 8'd0, 5'd24, 7'd79, 1, {5'd24, 7'd79, 8'd0, 8'd0, 2'b00});
        add_row(OP_READ, 8'd0, 8'd0, 5'd24, 7'd79, 0, '0);

        phase_color[0] = 8'd0;
        phase_color[1] = 8'd255;
        phase_color[2] = 8'($urandom_range(1, 254));
        phase_color[3] = 8'($urandom_range(1, 254));
        phase_color[4] = DEFAULT_COLOR_RESET;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
            idle_sender();
        end
        finish_phase();

        for (p = 0; p < 5; p++)
        begin
            write_default_color(phase_color[p]);
            no_idle = (p == 3);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                // The sink holds off while words keep coming, so the block backs up.
                if (p == 2 && n == 20)
                    stall_sink = 1;
                send_cmd(random_cmd(), 0, '0);
                idle_sender();
            end
            finish_phase();
        end
        no_idle = 0;

        repeat (2100) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
